// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked concurrent assertions used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// Clocked assertion that is checked in every cycle, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// File: sv/spsc_pkg.sv
// ----------------------------------------------------------------------------
// spsc_pkg
// Types and constants of the steering PID stepper controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spsc_pkg;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_MAC  = 6'b000100,
        ST_ABS  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    // Configuration register indexes.
    localparam logic [2:0] REG_GAIN_P     = 3'd0;
    localparam logic [2:0] REG_GAIN_I     = 3'd1;
    localparam logic [2:0] REG_GAIN_D     = 3'd2;
    localparam logic [2:0] REG_RIGHT_GOAL = 3'd3;
    localparam logic [2:0] REG_LEFT_GOAL  = 3'd4;
    localparam logic [2:0] REG_SPEED_NUM  = 3'd5;
    localparam logic [2:0] REG_PER_FLOOR  = 3'd6;
    localparam logic [2:0] REG_PER_CEIL   = 3'd7;

    // Register reset values.
    localparam logic [7:0]  RST_GAIN_P     = 8'd4;
    localparam logic [7:0]  RST_GAIN_I     = 8'd1;
    localparam logic [7:0]  RST_GAIN_D     = 8'd2;
    localparam logic [5:0]  RST_RIGHT_GOAL = 6'd2;
    localparam logic [6:0]  RST_LEFT_GOAL  = 7'h7E;
    localparam logic [15:0] RST_SPEED_NUM  = 16'd1000;
    localparam logic [15:0] RST_PER_FLOOR  = 16'd75;
    localparam logic [15:0] RST_PER_CEIL   = 16'd500;

    // Steering commands.
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_RIGHT  = 2'd1;
    localparam logic [1:0] ACT_LEFT   = 2'd2;
    localparam logic [1:0] ACT_CENTER = 2'd3;

    // Step direction codes.
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_REV  = 2'd1;
    localparam logic [1:0] DIR_FWD  = 2'd2;

    // Offset applied to a positive goal when forming the error.
    localparam logic signed [15:0] RIGHT_OFFSET = 16'sd5;

    // Error sum saturation limits, 24-bit signed, in the 25-bit adder width.
    localparam logic signed [24:0] SUM_MAX = 25'sd8388607;
    localparam logic signed [24:0] SUM_MIN = -25'sd8388608;

    // Divider iterations, one quotient bit each.
    localparam int DIV_STEPS = 16;
    // Multiply-accumulate passes: error, error sum, error change.
    localparam int MAC_PASSES = 3;

endpackage

// File: sv/steering_pid_stepper_control.sv
// ----------------------------------------------------------------------------
// steering_pid_stepper_control
// Steering position controller that turns a PID value into a step period.
// ----------------------------------------------------------------------------
// Each input beat carries a steering command and an encoder count; each one
// yields exactly one result beat. The block works on one beat at a time and
// holds o_in_stall high while busy. A beat that leaves the position off the
// goal passes through error and sum update, three passes through a single
// 24x9 signed multiply-accumulate unit, a magnitude step, sixteen passes of
// a restoring divider that forms one quotient bit a cycle, and a final step
// to clamp and load the output register. A zero control value skips the
// divider, and a beat that lands on the goal goes from the error update
// straight to the output load. The result waits in the output register
// when the receiver stalls; the sequencer holds in its last state until
// that register is free.
`timescale 1ns / 1ps

module steering_pid_stepper_control #(
    parameter int ENCODER_SPAN = 80
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [6:0]         i_encoder_count,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_step_dir,
    output logic [15:0]        o_step_period,
    output logic signed [7:0]  o_error_now
);

    // Position width: wide enough for the folded span and the raw count.
    localparam int SPAN_BITS = $clog2(ENCODER_SPAN + 1);
    localparam int POS_W     = ((SPAN_BITS > 7) ? SPAN_BITS : 7) + 2;
    localparam logic signed [POS_W-1:0] SPAN_S = POS_W'(ENCODER_SPAN);
    localparam logic signed [POS_W-1:0] HALF_S = POS_W'(ENCODER_SPAN / 2);

    // Configuration registers.
    logic [7:0]  r_gain_p, r_gain_i, r_gain_d;
    logic [5:0]  r_right_goal;
    logic [6:0]  r_left_goal;
    logic [15:0] r_speed_num, r_per_floor, r_per_ceil;

    // Controller state.
    logic signed [7:0]  r_goal;
    logic signed [15:0] r_err, r_prev;
    logic signed [23:0] r_sum;

    // Working registers.
    spsc_pkg::t_state   r_state;
    logic [1:0]         r_act;
    logic [6:0]         r_enc;
    logic signed [16:0] r_der;
    logic [1:0]         r_dir;
    logic               r_zero;
    logic [3:0]         r_step;
    logic signed [33:0] r_acc;
    logic [33:0]        r_mag;
    logic [15:0]        r_rem;
    logic [15:0]        r_quo;

    // Output register.
    logic               r_out_valid;
    logic [1:0]         r_out_dir;
    logic [15:0]        r_out_period;
    logic signed [7:0]  r_out_err;

    // ------------------------------------------------------------------
    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p     <= spsc_pkg::RST_GAIN_P;
            r_gain_i     <= spsc_pkg::RST_GAIN_I;
            r_gain_d     <= spsc_pkg::RST_GAIN_D;
            r_right_goal <= spsc_pkg::RST_RIGHT_GOAL;
            r_left_goal  <= spsc_pkg::RST_LEFT_GOAL;
            r_speed_num  <= spsc_pkg::RST_SPEED_NUM;
            r_per_floor  <= spsc_pkg::RST_PER_FLOOR;
            r_per_ceil   <= spsc_pkg::RST_PER_CEIL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spsc_pkg::REG_GAIN_P:     r_gain_p     <= i_cfg_data[7:0];
                spsc_pkg::REG_GAIN_I:     r_gain_i     <= i_cfg_data[7:0];
                spsc_pkg::REG_GAIN_D:     r_gain_d     <= i_cfg_data[7:0];
                spsc_pkg::REG_RIGHT_GOAL: r_right_goal <= i_cfg_data[5:0];
                spsc_pkg::REG_LEFT_GOAL:  r_left_goal  <= i_cfg_data[6:0];
                spsc_pkg::REG_SPEED_NUM:  r_speed_num  <= i_cfg_data;
                spsc_pkg::REG_PER_FLOOR:  r_per_floor  <= i_cfg_data;
                spsc_pkg::REG_PER_CEIL:   r_per_ceil   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake.
    logic w_in_acc;
    logic w_out_free;
    assign o_in_stall = (r_state != spsc_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // ------------------------------------------------------------------
    // Position fold, goal selection, error and sum update.
    logic signed [POS_W-1:0] w_cnt, w_pos;
    logic signed [7:0]       w_goal;
    logic signed [15:0]      w_pos16, w_goal16, w_err;
    logic signed [24:0]      w_sum_raw;
    logic signed [23:0]      w_sum;
    logic                    w_at_goal;
    logic [1:0]              w_dir;

    always_comb begin
        w_cnt = signed'({{(POS_W - 7){1'b0}}, r_enc});
        w_pos = (w_cnt > HALF_S) ? (w_cnt - SPAN_S) : w_cnt;

        case (r_act)
            spsc_pkg::ACT_RIGHT:  w_goal = signed'({2'b00, r_right_goal});
            spsc_pkg::ACT_LEFT:   w_goal = signed'({r_left_goal[6], r_left_goal});
            spsc_pkg::ACT_CENTER: w_goal = '0;
            default:              w_goal = r_goal;
        endcase

        w_pos16   = signed'({{(16 - POS_W){w_pos[POS_W-1]}}, w_pos});
        w_goal16  = signed'({{8{w_goal[7]}}, w_goal});
        w_at_goal = (w_pos16 == w_goal16);

        // A zero goal keeps the previous error.
        if (w_goal > 8'sd0) begin
            w_err = w_pos16 - spsc_pkg::RIGHT_OFFSET + w_goal16;
        end else if (w_goal < 8'sd0) begin
            w_err = w_pos16 - w_goal16;
        end else begin
            w_err = r_err;
        end

        w_sum_raw = signed'({r_sum[23], r_sum}) + signed'({{9{w_err[15]}}, w_err});
        if (w_sum_raw > spsc_pkg::SUM_MAX) begin
            w_sum = spsc_pkg::SUM_MAX[23:0];
        end else if (w_sum_raw < spsc_pkg::SUM_MIN) begin
            w_sum = spsc_pkg::SUM_MIN[23:0];
        end else begin
            w_sum = w_sum_raw[23:0];
        end

        if (w_goal < 8'sd0) begin
            w_dir = (w_pos16 < w_goal16) ? spsc_pkg::DIR_REV : spsc_pkg::DIR_FWD;
        end else if (w_goal > 8'sd0) begin
            w_dir = (w_pos16 > w_goal16) ? spsc_pkg::DIR_FWD : spsc_pkg::DIR_REV;
        end else begin
            w_dir = (w_pos16 < 16'sd0) ? spsc_pkg::DIR_REV : spsc_pkg::DIR_FWD;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiply-accumulate unit: one term per pass.
    logic signed [23:0] w_mac_op;
    logic [7:0]         w_mac_gain;
    logic signed [32:0] w_prod;

    always_comb begin
        case (r_step[1:0])
            2'd0: begin
                w_mac_op   = signed'({{8{r_err[15]}}, r_err});
                w_mac_gain = r_gain_p;
            end
            2'd1: begin
                w_mac_op   = r_sum;
                w_mac_gain = r_gain_i;
            end
            default: begin
                w_mac_op   = signed'({{7{r_der[16]}}, r_der});
                w_mac_gain = r_gain_d;
            end
        endcase
        w_prod = w_mac_op * signed'({1'b0, w_mac_gain});
    end

    // ------------------------------------------------------------------
    // Restoring divider step and period clamp.
    logic [16:0] w_trial;
    logic        w_fits;
    logic [15:0] w_period;

    always_comb begin
        w_trial = {r_rem, r_quo[15]};
        w_fits  = ({17'd0, w_trial} >= r_mag);

        if (r_zero) begin
            w_period = '0;
        end else if (r_quo < r_per_floor) begin
            w_period = r_per_floor;
        end else if (r_quo > r_per_ceil) begin
            w_period = r_per_ceil;
        end else begin
            w_period = r_quo;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spsc_pkg::ST_IDLE;
            r_goal  <= '0;
            r_err   <= '0;
            r_prev  <= '0;
            r_sum   <= '0;
            r_step  <= '0;
        end else begin
            case (r_state)
                spsc_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= spsc_pkg::ST_PREP;
                    end
                end
                spsc_pkg::ST_PREP: begin
                    r_goal <= w_goal;
                    r_step <= '0;
                    if (w_at_goal) begin
                        r_err   <= '0;
                        r_prev  <= '0;
                        r_sum   <= '0;
                        r_state <= spsc_pkg::ST_DONE;
                    end else begin
                        r_err   <= w_err;
                        r_prev  <= w_err;
                        r_sum   <= w_sum;
                        r_state <= spsc_pkg::ST_MAC;
                    end
                end
                spsc_pkg::ST_MAC: begin
                    if (r_step == 4'(spsc_pkg::MAC_PASSES - 1)) begin
                        r_step  <= '0;
                        r_state <= spsc_pkg::ST_ABS;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                spsc_pkg::ST_ABS: begin
                    r_state <= (r_acc == '0) ? spsc_pkg::ST_DONE : spsc_pkg::ST_DIV;
                end
                spsc_pkg::ST_DIV: begin
                    if (r_step == 4'(spsc_pkg::DIV_STEPS - 1)) begin
                        r_step  <= '0;
                        r_state <= spsc_pkg::ST_DONE;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                spsc_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= spsc_pkg::ST_IDLE;
                    end
                end
                default: r_state <= spsc_pkg::ST_IDLE;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            spsc_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    r_act <= i_action;
                    r_enc <= i_encoder_count;
                end
            end
            spsc_pkg::ST_PREP: begin
                r_der  <= signed'({w_err[15], w_err}) - signed'({r_prev[15], r_prev});
                r_dir  <= w_at_goal ? spsc_pkg::DIR_NONE : w_dir;
                r_zero <= w_at_goal;
                r_acc  <= '0;
            end
            spsc_pkg::ST_MAC: begin
                r_acc <= r_acc + signed'({w_prod[32], w_prod});
            end
            spsc_pkg::ST_ABS: begin
                r_mag <= r_acc[33] ? 34'(-r_acc) : 34'(r_acc);
                r_rem <= '0;
                // A zero control value takes the ceiling before the clamp.
                r_quo <= (r_acc == '0) ? r_per_ceil : r_speed_num;
            end
            spsc_pkg::ST_DIV: begin
                r_rem <= w_fits ? 16'(w_trial - r_mag[16:0]) : w_trial[15:0];
                r_quo <= {r_quo[14:0], w_fits};
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == spsc_pkg::ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == spsc_pkg::ST_DONE && w_out_free) begin
            r_out_dir    <= r_dir;
            r_out_period <= w_period;
            r_out_err    <= r_err[7:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_step_dir    = r_out_dir;
    assign o_step_period = r_out_period;
    assign o_error_now   = r_out_err;

endmodule

// File: sv/spsc_checker.sv
// ----------------------------------------------------------------------------
// spsc_checker
// Port-level checks of the steering PID stepper controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module spsc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_step_dir,
    input logic [15:0]        o_step_period,
    input logic signed [7:0]  o_error_now
);

    // Short names for the handshake and payload conditions.
    logic        w_in_beat;
    logic        w_out_held;
    logic        w_no_step;
    logic        w_cleared;
    logic [25:0] w_payload;

    assign w_in_beat  = i_in_valid && !o_in_stall;
    assign w_out_held = o_out_valid && i_out_stall;
    assign w_no_step  = o_out_valid && (o_step_dir == spsc_pkg::DIR_NONE);
    assign w_cleared  = (o_step_period == 16'd0) && (o_error_now == 8'sd0);
    assign w_payload  = {o_step_dir, o_step_period, o_error_now};

    // An accepted beat keeps the block busy in the following cycle.
    `ASSERT_CLK_RST(a_busy_after_accept, i_clk, i_rst_n, w_in_beat |=> o_in_stall)

    // A result appears only while the block was still busy with its beat.
    `ASSERT_CLK_RST(a_result_from_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall))

    // A beat with no step reports a zero period and a cleared error.
    `ASSERT_CLK_RST(a_no_step_clear, i_clk, i_rst_n, w_no_step |-> w_cleared)

    // A stalled result beat holds its payload.
    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, w_out_held |=> (o_out_valid && $stable(w_payload)))

endmodule

bind steering_pid_stepper_control spsc_checker u_spsc_checker (.*);
